[rtl/mips_subset_decode_alu_unit_assert.svh]
// Assertion macros used by the checker file of the decode/ALU unit.
// Each macro takes a label, clock, active-low reset, antecedent, consequent
// and a message string.
`ifndef MIPS_SUBSET_DECODE_ALU_UNIT_ASSERT_SVH
`define MIPS_SUBSET_DECODE_ALU_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MSDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/msda_pkg.sv]
// ----------------------------------------------------------------------------
// msda_pkg
// Opcode, function and mnemonic id codes of the decode/ALU unit.
// ----------------------------------------------------------------------------
`default_nettype none

package msda_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IMM_W  = 16;
    localparam int unsigned CODE_W = 6;
    localparam int unsigned REG_W  = 5;
    localparam int unsigned ID_W   = 6;
    localparam int unsigned SHAMT_W = 5;

    // R-type function codes
    localparam logic [CODE_W-1:0] FN_SLL  = 6'h00;
    localparam logic [CODE_W-1:0] FN_SRL  = 6'h02;
    localparam logic [CODE_W-1:0] FN_SRA  = 6'h03;
    localparam logic [CODE_W-1:0] FN_JR   = 6'h08;
    localparam logic [CODE_W-1:0] FN_ADD  = 6'h20;
    localparam logic [CODE_W-1:0] FN_SUB  = 6'h22;
    localparam logic [CODE_W-1:0] FN_AND  = 6'h24;
    localparam logic [CODE_W-1:0] FN_OR   = 6'h25;
    localparam logic [CODE_W-1:0] FN_XOR  = 6'h26;
    localparam logic [CODE_W-1:0] FN_NOR  = 6'h27;
    localparam logic [CODE_W-1:0] FN_NAND = 6'h28;
    localparam logic [CODE_W-1:0] FN_SLT  = 6'h2A;

    // primary opcodes
    localparam logic [CODE_W-1:0] OP_RTYPE = 6'h00;
    localparam logic [CODE_W-1:0] OP_J     = 6'h02;
    localparam logic [CODE_W-1:0] OP_JAL   = 6'h03;
    localparam logic [CODE_W-1:0] OP_BEQ   = 6'h04;
    localparam logic [CODE_W-1:0] OP_BNE   = 6'h05;
    localparam logic [CODE_W-1:0] OP_ADDI  = 6'h08;
    localparam logic [CODE_W-1:0] OP_SLTI  = 6'h0A;
    localparam logic [CODE_W-1:0] OP_ANDI  = 6'h0C;
    localparam logic [CODE_W-1:0] OP_ORI   = 6'h0D;
    localparam logic [CODE_W-1:0] OP_NORI  = 6'h0E;
    localparam logic [CODE_W-1:0] OP_LUI   = 6'h0F;
    localparam logic [CODE_W-1:0] OP_LB    = 6'h20;
    localparam logic [CODE_W-1:0] OP_LH    = 6'h21;
    localparam logic [CODE_W-1:0] OP_LW    = 6'h23;
    localparam logic [CODE_W-1:0] OP_LBU   = 6'h24;
    localparam logic [CODE_W-1:0] OP_LHU   = 6'h25;
    localparam logic [CODE_W-1:0] OP_SB    = 6'h28;
    localparam logic [CODE_W-1:0] OP_SH    = 6'h29;
    localparam logic [CODE_W-1:0] OP_SW    = 6'h2B;
    localparam logic [CODE_W-1:0] OP_HALT  = 6'h3F;

    // mnemonic ids
    localparam logic [ID_W-1:0] ID_UNKNOWN = 6'd0;
    localparam logic [ID_W-1:0] ID_ADD  = 6'd1;
    localparam logic [ID_W-1:0] ID_SUB  = 6'd2;
    localparam logic [ID_W-1:0] ID_AND  = 6'd3;
    localparam logic [ID_W-1:0] ID_OR   = 6'd4;
    localparam logic [ID_W-1:0] ID_XOR  = 6'd5;
    localparam logic [ID_W-1:0] ID_NOR  = 6'd6;
    localparam logic [ID_W-1:0] ID_NAND = 6'd7;
    localparam logic [ID_W-1:0] ID_SLT  = 6'd8;
    localparam logic [ID_W-1:0] ID_NOP  = 6'd9;
    localparam logic [ID_W-1:0] ID_SLL  = 6'd10;
    localparam logic [ID_W-1:0] ID_SRL  = 6'd11;
    localparam logic [ID_W-1:0] ID_SRA  = 6'd12;
    localparam logic [ID_W-1:0] ID_JR   = 6'd13;
    localparam logic [ID_W-1:0] ID_ADDI = 6'd14;
    localparam logic [ID_W-1:0] ID_LW   = 6'd15;
    localparam logic [ID_W-1:0] ID_LH   = 6'd16;
    localparam logic [ID_W-1:0] ID_LHU  = 6'd17;
    localparam logic [ID_W-1:0] ID_LB   = 6'd18;
    localparam logic [ID_W-1:0] ID_LBU  = 6'd19;
    localparam logic [ID_W-1:0] ID_SW   = 6'd20;
    localparam logic [ID_W-1:0] ID_SH   = 6'd21;
    localparam logic [ID_W-1:0] ID_SB   = 6'd22;
    localparam logic [ID_W-1:0] ID_LUI  = 6'd23;
    localparam logic [ID_W-1:0] ID_ANDI = 6'd24;
    localparam logic [ID_W-1:0] ID_ORI  = 6'd25;
    localparam logic [ID_W-1:0] ID_NORI = 6'd26;
    localparam logic [ID_W-1:0] ID_SLTI = 6'd27;
    localparam logic [ID_W-1:0] ID_BEQ  = 6'd28;
    localparam logic [ID_W-1:0] ID_BNE  = 6'd29;
    localparam logic [ID_W-1:0] ID_J    = 6'd30;
    localparam logic [ID_W-1:0] ID_JAL  = 6'd31;
    localparam logic [ID_W-1:0] ID_HALT = 6'd32;

endpackage

`default_nettype wire

[rtl/mips_subset_decode_alu_unit.sv]
// ----------------------------------------------------------------------------
// mips_subset_decode_alu_unit
// Decode and execute stage: input register, one pass of decode/ALU logic,
// result register.
// ----------------------------------------------------------------------------
// An input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low; set by the single decode/ALU pass.
// in_stall follows out_stall only when both registers hold a beat.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none

module mips_subset_decode_alu_unit
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [msda_pkg::CODE_W-1:0]          opcode,
    input  wire logic [msda_pkg::CODE_W-1:0]          funct,
    input  wire logic [msda_pkg::REG_W-1:0]           rt_num,
    input  wire logic [msda_pkg::REG_W-1:0]           rd_num,
    input  wire logic signed [msda_pkg::IMM_W-1:0]    imm,
    input  wire logic signed [msda_pkg::DATA_W-1:0]   rs_value,
    input  wire logic signed [msda_pkg::DATA_W-1:0]   rt_value,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [msda_pkg::DATA_W-1:0]        exec_value,
    output logic [msda_pkg::ID_W-1:0]                 mnemonic_id
);

    // input register
    logic                              in_valid_reg;
    logic [msda_pkg::CODE_W-1:0]       opcode_reg;
    logic [msda_pkg::CODE_W-1:0]       funct_reg;
    logic [msda_pkg::REG_W-1:0]        rt_num_reg;
    logic [msda_pkg::REG_W-1:0]        rd_num_reg;
    logic [msda_pkg::IMM_W-1:0]        imm_reg;
    logic [msda_pkg::DATA_W-1:0]       rs_value_reg;
    logic [msda_pkg::DATA_W-1:0]       rt_value_reg;

    // result register
    logic                              out_valid_reg;
    logic [msda_pkg::DATA_W-1:0]       exec_value_reg;
    logic [msda_pkg::ID_W-1:0]         mnemonic_id_reg;
    logic [msda_pkg::DATA_W-1:0]       exec_value_next;
    logic [msda_pkg::ID_W-1:0]         mnemonic_id_next;

    logic                              res_free;
    logic                              advance;
    logic                              in_take;

    logic [msda_pkg::DATA_W-1:0]       imm_se;
    logic [msda_pkg::DATA_W-1:0]       imm_ze;
    logic [msda_pkg::DATA_W-1:0]       addr_sum;
    logic [msda_pkg::SHAMT_W-1:0]      shamt;
    logic                              is_nop;

    assign res_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && res_free;
    assign in_stall = in_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg   <= opcode;
            funct_reg    <= funct;
            rt_num_reg   <= rt_num;
            rd_num_reg   <= rd_num;
            imm_reg      <= imm;
            rs_value_reg <= rs_value;
            rt_value_reg <= rt_value;
        end
        if (advance)
        begin
            exec_value_reg  <= exec_value_next;
            mnemonic_id_reg <= mnemonic_id_next;
        end
    end

    assign imm_se   = {{(msda_pkg::DATA_W-msda_pkg::IMM_W){imm_reg[msda_pkg::IMM_W-1]}},
                       imm_reg};
    assign imm_ze   = {{(msda_pkg::DATA_W-msda_pkg::IMM_W){1'b0}}, imm_reg};
    assign addr_sum = rs_value_reg + imm_se;
    assign shamt    = imm_reg[msda_pkg::SHAMT_W-1:0];
    // all-zero instruction word under funct 0
    assign is_nop   = (rt_num_reg == '0) && (rd_num_reg == '0) && (imm_reg == '0);

    always_comb
    begin
        exec_value_next  = '0;
        mnemonic_id_next = msda_pkg::ID_UNKNOWN;
        if (opcode_reg == msda_pkg::OP_RTYPE)
        begin
            unique case (funct_reg)
                msda_pkg::FN_ADD:
                begin
                    exec_value_next  = rs_value_reg + rt_value_reg;
                    mnemonic_id_next = msda_pkg::ID_ADD;
                end
                msda_pkg::FN_SUB:
                begin
                    exec_value_next  = rs_value_reg - rt_value_reg;
                    mnemonic_id_next = msda_pkg::ID_SUB;
                end
                msda_pkg::FN_AND:
                begin
                    exec_value_next  = rs_value_reg & rt_value_reg;
                    mnemonic_id_next = msda_pkg::ID_AND;
                end
                msda_pkg::FN_OR:
                begin
                    exec_value_next  = rs_value_reg | rt_value_reg;
                    mnemonic_id_next = msda_pkg::ID_OR;
                end
                msda_pkg::FN_XOR:
                begin
                    exec_value_next  = rs_value_reg ^ rt_value_reg;
                    mnemonic_id_next = msda_pkg::ID_XOR;
                end
                msda_pkg::FN_NOR:
                begin
                    exec_value_next  = ~(rs_value_reg | rt_value_reg);
                    mnemonic_id_next = msda_pkg::ID_NOR;
                end
                msda_pkg::FN_NAND:
                begin
                    exec_value_next  = ~(rs_value_reg & rt_value_reg);
                    mnemonic_id_next = msda_pkg::ID_NAND;
                end
                msda_pkg::FN_SLT:
                begin
                    exec_value_next  = {{(msda_pkg::DATA_W-1){1'b0}},
                                        $signed(rs_value_reg) < $signed(rt_value_reg)};
                    mnemonic_id_next = msda_pkg::ID_SLT;
                end
                msda_pkg::FN_SLL:
                begin
                    exec_value_next  = rt_value_reg << shamt;
                    mnemonic_id_next = is_nop ? msda_pkg::ID_NOP : msda_pkg::ID_SLL;
                end
                msda_pkg::FN_SRL:
                begin
                    exec_value_next  = rt_value_reg >> shamt;
                    mnemonic_id_next = msda_pkg::ID_SRL;
                end
                msda_pkg::FN_SRA:
                begin
                    exec_value_next  = $unsigned($signed(rt_value_reg) >>> shamt);
                    mnemonic_id_next = msda_pkg::ID_SRA;
                end
                msda_pkg::FN_JR:
                begin
                    mnemonic_id_next = msda_pkg::ID_JR;
                end
                default:
                begin
                    mnemonic_id_next = msda_pkg::ID_UNKNOWN;
                end
            endcase
        end
        else
        begin
            // value path: loads and stores share the address adder with addi
            case (opcode_reg) inside
                msda_pkg::OP_ADDI, msda_pkg::OP_LW, msda_pkg::OP_LH, msda_pkg::OP_LHU,
                msda_pkg::OP_LB, msda_pkg::OP_LBU, msda_pkg::OP_SW, msda_pkg::OP_SH,
                msda_pkg::OP_SB:
                    exec_value_next = addr_sum;
                msda_pkg::OP_LUI:
                    exec_value_next = {imm_reg, {(msda_pkg::DATA_W-msda_pkg::IMM_W){1'b0}}};
                msda_pkg::OP_ANDI:
                    exec_value_next = rs_value_reg & imm_ze;
                msda_pkg::OP_ORI:
                    exec_value_next = rs_value_reg | imm_ze;
                msda_pkg::OP_NORI:
                    exec_value_next = ~(rs_value_reg | imm_ze);
                msda_pkg::OP_SLTI:
                    exec_value_next = {{(msda_pkg::DATA_W-1){1'b0}},
                                       $signed(rs_value_reg) < $signed(imm_se)};
                default:
                    exec_value_next = '0;
            endcase

            unique case (opcode_reg)
                msda_pkg::OP_ADDI: mnemonic_id_next = msda_pkg::ID_ADDI;
                msda_pkg::OP_LW:   mnemonic_id_next = msda_pkg::ID_LW;
                msda_pkg::OP_LH:   mnemonic_id_next = msda_pkg::ID_LH;
                msda_pkg::OP_LHU:  mnemonic_id_next = msda_pkg::ID_LHU;
                msda_pkg::OP_LB:   mnemonic_id_next = msda_pkg::ID_LB;
                msda_pkg::OP_LBU:  mnemonic_id_next = msda_pkg::ID_LBU;
                msda_pkg::OP_SW:   mnemonic_id_next = msda_pkg::ID_SW;
                msda_pkg::OP_SH:   mnemonic_id_next = msda_pkg::ID_SH;
                msda_pkg::OP_SB:   mnemonic_id_next = msda_pkg::ID_SB;
                msda_pkg::OP_LUI:  mnemonic_id_next = msda_pkg::ID_LUI;
                msda_pkg::OP_ANDI: mnemonic_id_next = msda_pkg::ID_ANDI;
                msda_pkg::OP_ORI:  mnemonic_id_next = msda_pkg::ID_ORI;
                msda_pkg::OP_NORI: mnemonic_id_next = msda_pkg::ID_NORI;
                msda_pkg::OP_SLTI: mnemonic_id_next = msda_pkg::ID_SLTI;
                msda_pkg::OP_BEQ:  mnemonic_id_next = msda_pkg::ID_BEQ;
                msda_pkg::OP_BNE:  mnemonic_id_next = msda_pkg::ID_BNE;
                msda_pkg::OP_J:    mnemonic_id_next = msda_pkg::ID_J;
                msda_pkg::OP_JAL:  mnemonic_id_next = msda_pkg::ID_JAL;
                msda_pkg::OP_HALT: mnemonic_id_next = msda_pkg::ID_HALT;
                default:           mnemonic_id_next = msda_pkg::ID_UNKNOWN;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign exec_value  = exec_value_reg;
    assign mnemonic_id = mnemonic_id_reg;

endmodule

`default_nettype wire

[rtl/msda_checker.sv]
// ----------------------------------------------------------------------------
// msda_checker
// Port-level checks on the decode/ALU unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mips_subset_decode_alu_unit_assert.svh"

module msda_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_stall,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    input  wire logic signed [msda_pkg::DATA_W-1:0]   exec_value,
    input  wire logic [msda_pkg::ID_W-1:0]            mnemonic_id
);

    logic no_alu_id;
    logic slt_id;

    // NOP is left out: it passes rt_value through unshifted
    assign no_alu_id = (mnemonic_id == msda_pkg::ID_UNKNOWN) ||
                       (mnemonic_id == msda_pkg::ID_JR) ||
                       (mnemonic_id == msda_pkg::ID_BEQ) ||
                       (mnemonic_id == msda_pkg::ID_BNE) ||
                       (mnemonic_id == msda_pkg::ID_J) ||
                       (mnemonic_id == msda_pkg::ID_JAL) ||
                       (mnemonic_id == msda_pkg::ID_HALT);
    assign slt_id    = (mnemonic_id == msda_pkg::ID_SLT) ||
                       (mnemonic_id == msda_pkg::ID_SLTI);

    // a stalled result beat holds
    `MSDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(exec_value) && $stable(mnemonic_id), "stalled result beat changed")

    `MSDA_ASSERT_IMPLY(a_id_range, clk, rst_n, out_valid, mnemonic_id <= msda_pkg::ID_HALT, "mnemonic id out of range")

    `MSDA_ASSERT_IMPLY(a_no_alu_zero, clk, rst_n, out_valid && no_alu_id, exec_value == '0, "nonzero value for instruction without ALU work")

    `MSDA_ASSERT_IMPLY(a_slt_bool, clk, rst_n, out_valid && slt_id, exec_value[msda_pkg::DATA_W-1:1] == '0, "set-less-than result not 0 or 1")

    // input side can only be held off while the result side is blocked
    `MSDA_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_valid && in_stall, out_valid && out_stall, "input stalled with free result register")

endmodule

bind mips_subset_decode_alu_unit msda_checker u_msda_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .exec_value  (exec_value),
    .mnemonic_id (mnemonic_id)
);

`default_nettype wire
